### src/trkul_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the text record key lookup block.
// No dependencies; imported by text_record_key_uid_lookup.
package trkul_pkg;

    // Line parser phases
    localparam logic [2:0] PH_NAME   = 3'd0;
    localparam logic [2:0] PH_BLANKS = 3'd1;
    localparam logic [2:0] PH_NUMBER = 3'd2;
    localparam logic [2:0] PH_BADNUM = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;

    // Latched error, first one wins
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_DUPLICATE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NO_MATCH  = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_EMPTY_KEY = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;

    // Input action codes
    localparam logic ACT_BYTE        = 1'b0;
    localparam logic ACT_END_OF_LIST = 1'b1;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Key register layout: four 64-bit words, eight bytes each
    localparam int KEY_VIEW_BYTES = 32;
    localparam int KEY_WORD_BYTES = 8;
    localparam logic [5:0] POS_MAX = 6'd63;

endpackage

### src/text_record_key_uid_lookup.sv
`timescale 1ns / 1ps
// Top level of the text record key lookup: byte parser, key store and result register.
// Depends on trkul_pkg.
//
// Looks up one keyed record in a newline-separated text list streamed in one byte per
// transfer. The first field of each line (ending at space or tab) is compared with the
// configured key; on a match the decimal 32-bit number after the blanks is taken. An
// end-of-list transfer (tuser = 1) yields one result transfer with found, number and
// status, and clears the list state. The block takes one transfer per cycle unless an end
// marker waits on a pending result. Each byte is held in the input register, then a single
// pass through the key-byte compare and the multiply-by-ten accumulate updates the parser
// state; the result is loaded into the output register as the end marker leaves the input
// register. A pending result stalls only end markers, list bytes keep flowing behind it.
// The user must write configuration only while the block is idle; the block does not enforce it.
module text_record_key_uid_lookup #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // list byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [0] found, [32:1] uid_value, [35:33] status, zero pad
);
    import trkul_pkg::*;

    localparam int KEY_WORDS = (MAX_KEY_BYTES + KEY_WORD_BYTES - 1) / KEY_WORD_BYTES;
    localparam logic [5:0] KEY_BYTES_LIMIT = 6'(MAX_KEY_BYTES);

    // configuration
    logic [5:0]  key_length_reg;
    logic [63:0] key_word_reg [KEY_WORDS];
    logic [7:0]  key_bytes [KEY_VIEW_BYTES];

    // input register
    logic        in_valid_reg;
    logic        in_action_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    logic [2:0]  phase_reg,       phase_next;
    logic [5:0]  pos_reg,         pos_next;
    logic        differs_reg,     differs_next;
    logic [31:0] acc_reg,         acc_next;
    logic        started_reg,     started_next;
    logic        match_seen_reg,  match_seen_next;
    logic [31:0] saved_reg,       saved_next;
    logic [1:0]  error_reg,       error_next;

    // output register
    logic        m_valid_reg;
    logic [39:0] m_data_reg;

    logic        advance;
    logic [7:0]  ch;
    logic        blank;
    logic        is_digit;
    logic [2:0]  eff_phase;
    logic [31:0] eff_acc;
    logic        eff_started;
    logic        key_hit;
    logic [35:0] acc_wide;
    logic        found_res;
    logic [31:0] uid_res;
    logic [2:0]  status_res;

    for (genvar b = 0; b < KEY_VIEW_BYTES; b++) begin : g_key_view
        if (b < KEY_WORDS * KEY_WORD_BYTES) begin : g_stored
            assign key_bytes[b] =
                key_word_reg[b / KEY_WORD_BYTES][(b % KEY_WORD_BYTES) * 8 +: 8];
        end else begin : g_absent
            assign key_bytes[b] = '0;
        end
    end

    // a byte moves on unless it is an end marker and the result slot is still full
    assign advance  = in_valid_reg &&
                      (in_action_reg == ACT_BYTE || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        ch       = (in_action_reg == ACT_END_OF_LIST) ? CH_LF : in_byte_reg;
        blank    = (ch == CH_SPACE) || (ch == CH_TAB);
        is_digit = ch inside {[CH_ZERO:CH_NINE]};

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        differs_next    = differs_reg;
        acc_next        = acc_reg;
        started_next    = started_reg;
        match_seen_next = match_seen_reg;
        saved_next      = saved_reg;
        error_next      = error_reg;

        // first byte after the blanks starts the number and is parsed as part of it
        eff_phase   = phase_reg;
        eff_acc     = acc_reg;
        eff_started = started_reg;
        if (phase_reg == PH_BLANKS && !blank && ch != CH_LF && ch != CH_CR) begin
            eff_phase   = PH_NUMBER;
            eff_acc     = '0;
            eff_started = 1'b0;
        end
        acc_next     = eff_acc;
        started_next = eff_started;

        key_hit  = (pos_reg < key_length_reg) && (pos_reg < KEY_BYTES_LIMIT) &&
                   (key_bytes[pos_reg[4:0]] == ch);
        acc_wide = ({4'b0, eff_acc} << 3) + ({4'b0, eff_acc} << 1) +
                   {28'b0, ch - CH_ZERO};

        case (eff_phase)
            PH_NAME: begin
                if (ch == CH_LF) begin
                    phase_next   = PH_NAME;
                    pos_next     = '0;
                    differs_next = 1'b0;
                    acc_next     = '0;
                    started_next = 1'b0;
                end else if (blank) begin
                    phase_next = (!differs_reg && pos_reg == key_length_reg) ?
                                 PH_BLANKS : PH_SKIP;
                end else begin
                    if (!key_hit) begin
                        differs_next = 1'b1;
                    end
                    if (pos_reg != POS_MAX) begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
            end
            PH_BLANKS: begin
                if (ch == CH_LF) begin
                    if (error_reg == ERR_NONE) error_next = ERR_MALFORMED;
                    phase_next   = PH_NAME;
                    pos_next     = '0;
                    differs_next = 1'b0;
                    acc_next     = '0;
                    started_next = 1'b0;
                end else if (ch == CH_CR) begin
                    if (error_reg == ERR_NONE) error_next = ERR_MALFORMED;
                    phase_next = PH_SKIP;
                end
            end
            PH_NUMBER, PH_BADNUM: begin
                if (blank || ch == CH_CR || ch == CH_LF) begin
                    // number ends: malformed check comes before the duplicate check
                    if (eff_phase != PH_NUMBER || !eff_started) begin
                        if (error_reg == ERR_NONE) error_next = ERR_MALFORMED;
                    end else if (error_reg == ERR_NONE) begin
                        if (match_seen_reg) begin
                            error_next = ERR_DUPLICATE;
                        end else begin
                            match_seen_next = 1'b1;
                            saved_next      = eff_acc;
                        end
                    end
                    if (ch == CH_LF) begin
                        phase_next   = PH_NAME;
                        pos_next     = '0;
                        differs_next = 1'b0;
                        acc_next     = '0;
                        started_next = 1'b0;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end else if (eff_phase == PH_NUMBER) begin
                    if (is_digit && acc_wide[35:32] == 4'd0) begin
                        phase_next   = PH_NUMBER;
                        acc_next     = acc_wide[31:0];
                        started_next = 1'b1;
                    end else begin
                        phase_next = PH_BADNUM;
                    end
                end
            end
            default: begin
                if (ch == CH_LF) begin
                    phase_next   = PH_NAME;
                    pos_next     = '0;
                    differs_next = 1'b0;
                    acc_next     = '0;
                    started_next = 1'b0;
                end
            end
        endcase

        found_res = 1'b0;
        uid_res   = '0;
        if (key_length_reg == 6'd0) begin
            status_res = ST_EMPTY_KEY;
        end else if (error_next == ERR_MALFORMED) begin
            status_res = ST_MALFORMED;
        end else if (error_next == ERR_DUPLICATE) begin
            status_res = ST_DUPLICATE;
        end else if (match_seen_next) begin
            status_res = ST_FOUND;
            found_res  = 1'b1;
            uid_res    = saved_next;
        end else begin
            status_res = ST_NO_MATCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= '0;
            for (int w = 0; w < KEY_WORDS; w++) begin
                key_word_reg[w] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == CFG_KEY_LENGTH) begin
                key_length_reg <= cfg_data[5:0];
            end
            for (int w = 0; w < KEY_WORDS; w++) begin
                if (cfg_index == CFG_KEY_WORD_0 + 3'(w)) begin
                    key_word_reg[w] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_NAME;
            pos_reg        <= '0;
            differs_reg    <= 1'b0;
            acc_reg        <= '0;
            started_reg    <= 1'b0;
            match_seen_reg <= 1'b0;
            saved_reg      <= '0;
            error_reg      <= ERR_NONE;
        end else if (advance) begin
            if (in_action_reg == ACT_END_OF_LIST) begin
                phase_reg      <= PH_NAME;
                pos_reg        <= '0;
                differs_reg    <= 1'b0;
                acc_reg        <= '0;
                started_reg    <= 1'b0;
                match_seen_reg <= 1'b0;
                saved_reg      <= '0;
                error_reg      <= ERR_NONE;
            end else begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                differs_reg    <= differs_next;
                acc_reg        <= acc_next;
                started_reg    <= started_next;
                match_seen_reg <= match_seen_next;
                saved_reg      <= saved_next;
                error_reg      <= error_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_action_reg == ACT_END_OF_LIST) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_action_reg == ACT_END_OF_LIST) begin
            m_data_reg <= {4'b0, status_res, uid_res, found_res};
        end
    end

`ifndef SYNTHESIS
    // found is set exactly when the status says found
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[0] == (m_data_reg[35:33] == ST_FOUND)))
        else $error("found flag disagrees with status");

    // no number is reported without a match
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[0]) |-> (m_data_reg[32:1] == 32'd0))
        else $error("nonzero number on a result without match");

    // an end-of-list transfer leaves the list state clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_action_reg == ACT_END_OF_LIST) |=>
            (phase_reg == PH_NAME && !match_seen_reg && error_reg == ERR_NONE))
        else $error("list state not cleared after end of list");
`endif

endmodule
